// ===== rtl/core/pli_pkg.sv =====
// Package for the positional list core: field widths, operation and status
// codes, sequencer state type. No dependencies.
package pli_pkg;

    localparam int PL_CAPACITY = 16;

    localparam int KIND_W = 1;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_PUT,
        S_DROP,
        S_HEAD,
        S_TAIL,
        S_OUT
    } t_state;

endpackage

// ===== rtl/core/pli_ram.sv =====
// Entry store of the positional list core: one write and one registered read
// port per cycle. Depends on pli_pkg for the entry width.
module pli_ram #(
    parameter int DEPTH = pli_pkg::PL_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [pli_pkg::VAL_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [pli_pkg::VAL_W-1:0] o_rd_data
);
    import pli_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/positional_list_insert_delete_core.sv =====
// Top level of the positional list core: sequencer, count and index unit.
// Depends on pli_pkg and pli_ram.
//
// Usage: present i_kind, i_position and i_value with start; the item is taken
// at a rising edge where start is high and busy is low. busy stays high until
// the result has been shown. The result (o_status, o_length, o_head_value,
// o_tail_value) is valid for the single cycle in which o_done is high; the
// receiver cannot stall and must take it then.
// After an accepted item, the core moves length - position + 1 entries on
// insert, or length - position on delete, each with one read and one write
// through the registered read port of the entry store. It then writes the
// new value or drops the length, and then reads head and tail. A rejected
// item goes straight to the head and tail reads.
// busy falls after the o_done cycle, so a new item is taken only once the
// result of the last one has been shown.
// Reset (synchronous, active low) empties the list; store contents are not
// cleared, and an empty list shows zero head and tail values.
module positional_list_insert_delete_core #(
    parameter int CAPACITY = pli_pkg::PL_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pli_pkg::KIND_W-1:0]        i_kind,
    input  logic [pli_pkg::POS_W-1:0]         i_position,
    input  logic signed [pli_pkg::VAL_W-1:0]  i_value,
    output logic                              o_done,
    output logic [pli_pkg::STAT_W-1:0]        o_status,
    output logic [pli_pkg::LEN_W-1:0]         o_length,
    output logic signed [pli_pkg::VAL_W-1:0]  o_head_value,
    output logic signed [pli_pkg::VAL_W-1:0]  o_tail_value
);
    import pli_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int MW   = ((CW > POS_W) ? CW : POS_W) + 2;
    localparam int LW   = (CW > LEN_W) ? CW : LEN_W;

    t_state r_state, n_state;

    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_k, n_k;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [VAL_W-1:0]  r_value, n_value;
    logic [STAT_W-1:0] r_status, n_status;
    logic [VAL_W-1:0]  r_head, n_head;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [VAL_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [VAL_W-1:0]  ram_rd_data;

    logic              accept;
    logic [MW-1:0]     pos_m;
    logic [MW-1:0]     cnt_m;
    logic [MW-1:0]     k_m;
    logic [MW-1:0]     step_m;
    logic [STAT_W-1:0] chk_status;
    logic [AW-1:0]     idx_step;
    logic [LW-1:0]     count_w;

    assign accept = start && (r_state == S_IDLE);
    assign pos_m  = MW'(i_position);
    assign cnt_m  = MW'(r_count);
    assign k_m    = pos_m - MW'(1);

    // Shared index unit: step down on insert, up on delete
    assign idx_step = (r_kind == KIND_INSERT) ? (r_idx - AW'(1)) : (r_idx + AW'(1));
    assign step_m   = MW'(idx_step);

    always_comb begin
        chk_status = ST_OK;
        if (i_kind == KIND_INSERT) begin
            if (cnt_m >= MW'(CAPACITY)) begin
                chk_status = ST_FULL;
            end else if (pos_m == '0 || pos_m > cnt_m + MW'(1)) begin
                chk_status = ST_RANGE;
            end
        end else begin
            if (pos_m == '0 || pos_m > cnt_m) begin
                chk_status = ST_RANGE;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (chk_status != ST_OK) begin
                        n_state = S_HEAD;
                    end else if (i_kind == KIND_INSERT) begin
                        n_state = (cnt_m > k_m) ? S_INS_RD : S_PUT;
                    end else begin
                        n_state = (k_m + MW'(1) < cnt_m) ? S_DEL_RD : S_DROP;
                    end
                end
            end
            S_INS_RD: n_state = S_INS_WR;
            S_INS_WR: n_state = (step_m > MW'(r_k)) ? S_INS_RD : S_PUT;
            S_DEL_RD: n_state = S_DEL_WR;
            S_DEL_WR: n_state = (step_m + MW'(1) < cnt_m) ? S_DEL_RD : S_DROP;
            S_PUT:    n_state = S_HEAD;
            S_DROP:   n_state = S_HEAD;
            S_HEAD:   n_state = S_TAIL;
            S_TAIL:   n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_step;
        o_done      = 1'b0;
        busy        = 1'b1;
        case (r_state)
            S_IDLE:   busy = 1'b0;
            S_INS_RD: ram_rd_en = 1'b1;
            S_DEL_RD: ram_rd_en = 1'b1;
            S_INS_WR: ram_wr_en = 1'b1;
            S_DEL_WR: ram_wr_en = 1'b1;
            S_PUT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_k;
                ram_wr_data = r_value;
            end
            S_HEAD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
            end
            S_TAIL: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(r_count - CW'(1));
            end
            S_OUT:    o_done = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_idx    = r_idx;
        n_k      = r_k;
        n_kind   = r_kind;
        n_value  = r_value;
        n_status = r_status;
        n_head   = r_head;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind   = i_kind;
                    n_value  = i_value;
                    n_status = chk_status;
                    n_k      = AW'(k_m);
                    n_idx    = (i_kind == KIND_INSERT) ? AW'(r_count) : AW'(k_m);
                end
            end
            S_INS_WR: n_idx = idx_step;
            S_DEL_WR: n_idx = idx_step;
            S_PUT:    n_count = r_count + CW'(1);
            S_DROP:   n_count = r_count - CW'(1);
            S_TAIL:   n_head = ram_rd_data;
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_kind   <= n_kind;
        r_value  <= n_value;
        r_status <= n_status;
        r_head   <= n_head;
    end

    pli_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign count_w      = LW'(r_count);
    assign o_status     = r_status;
    assign o_length     = count_w[LEN_W-1:0];
    assign o_head_value = (r_count == '0) ? '0 : $signed(r_head);
    assign o_tail_value = (r_count == '0) ? '0 : $signed(ram_rd_data);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy held after result");

    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD) && (r_status != ST_OK) |-> $stable(r_count))
        else $error("rejected item changed the list length");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_count == '0) |-> (o_head_value == '0) && (o_tail_value == '0))
        else $error("empty list result with non-zero head or tail");
`endif

endmodule
